// ===== rtl/adcavg_pkg.sv =====
package adcavg_pkg;

    // Sample width of both ADC channels and of the limit registers.
    localparam int SAMPLE_W = 12;

    // Depth of the averaging window on the second channel.
    localparam int WINDOW = 4;

    // The running sum holds up to WINDOW full-scale samples.
    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);

    // Ring write pointer and fill count (the count reaches WINDOW itself).
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0] WIN_CNT = CNT_W'(WINDOW);

    // Divider iteration counter, one quotient bit per cycle.
    localparam int DCNT_W = $clog2(SUM_W + 1);
    localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(SUM_W);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT = 2'd1;

    // Reset values of the limit registers.
    localparam logic [SAMPLE_W-1:0] LOW_LIMIT_RST = 12'd100;
    localparam logic [SAMPLE_W-1:0] JUMP_LIMIT_RST = 12'd50;

    // Operands handed from the sequencer to the divider.
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

endpackage

// ===== rtl/adcavg_window.sv =====
module adcavg_window
    import adcavg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_update,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic [SUM_W-1:0]    o_sum,
    output logic [CNT_W-1:0]    o_fill
);

    logic [SAMPLE_W-1:0] r_ring [WINDOW];
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    n_sum;
    logic [SLOT_W-1:0]   r_slot;
    logic [SLOT_W-1:0]   n_slot;
    logic [CNT_W-1:0]    r_fill;
    logic [CNT_W-1:0]    n_fill;
    logic                full;
    logic [SAMPLE_W-1:0] oldest;

    // Until the window has filled, the slot being written was never written
    // and counts as zero, so the ring itself needs no reset.
    assign full   = (r_fill == WIN_CNT);
    assign oldest = full ? r_ring[r_slot] : '0;

    // Drop the oldest sample from the sum and add the new one.
    always_comb begin
        n_sum  = r_sum - SUM_W'(oldest) + SUM_W'(i_sample);
        n_slot = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
        n_fill = full ? r_fill : r_fill + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_slot <= '0;
            r_fill <= '0;
        end else if (i_update) begin
            r_sum  <= n_sum;
            r_slot <= n_slot;
            r_fill <= n_fill;
        end
    end

    // Sample ring.
    always_ff @(posedge i_clk) begin
        if (i_update) begin
            r_ring[r_slot] <= i_sample;
        end
    end

    assign o_sum  = r_sum;
    assign o_fill = r_fill;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= WIN_CNT)
        else $error("window fill count beyond window depth");

    a_slot_tracks_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != WIN_CNT) |-> (r_slot == r_fill[SLOT_W-1:0]))
        else $error("write slot out of step with fill count during warm-up");

endmodule

// ===== rtl/adcavg_div.sv =====
module adcavg_div
    import adcavg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_busy,
    output logic [SUM_W-1:0] o_quotient
);

    logic [DCNT_W-1:0] r_cnt;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_divisor;
    logic [CNT_W:0]    rem_shift;
    logic              fits;
    logic [CNT_W:0]    rem_sub;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb begin
        rem_shift = {r_rem, r_quo[SUM_W-1]};
        rem_sub   = rem_shift - {1'b0, r_divisor};
        fits      = (rem_shift >= {1'b0, r_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_cnt <= DIV_STEPS;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // The quotient register starts as the dividend and shifts quotient bits in.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo     <= i_req.dividend;
            r_rem     <= '0;
            r_divisor <= i_req.divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[SUM_W-2:0], fits};
            r_rem <= fits ? rem_sub[CNT_W-1:0] : rem_shift[CNT_W-1:0];
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> (r_divisor != '0))
        else $error("divide running with a zero divisor");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !o_busy)
        else $error("divider restarted while busy");

endmodule

// ===== rtl/adc_average_and_jump_alarm.sv =====
// Channel  Handshake                  Payload
// input    i_valid / o_ready          i_ch0_sample, i_ch1_sample
// output   o_valid / i_ready          o_ch0_value, o_ch1_mean, o_fault
// config   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A new request is taken only once the previous one has left the restoring
// divider, which works out one quotient bit per cycle.
// A finished result sits in the output register, and the next request is taken
// while it waits; only a second finished result stalls behind it.
// Reset is synchronous and active low; it clears the window, the previous-sample
// flag and the limits to 100 and 50. Configuration writes are taken every cycle.
module adc_average_and_jump_alarm
    import adcavg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [SAMPLE_W-1:0]  i_ch0_sample,
    input  logic [SAMPLE_W-1:0]  i_ch1_sample,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [SAMPLE_W-1:0]  o_ch0_value,
    output logic [SAMPLE_W-1:0]  o_ch1_mean,
    output logic                 o_fault,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SAMPLE_W-1:0]  i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_UPDATE = 5'b00010,
        S_LOAD   = 5'b00100,
        S_DIVIDE = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [SAMPLE_W-1:0] r_low_limit;
    logic [SAMPLE_W-1:0] r_jump_limit;
    logic [SAMPLE_W-1:0] r_ch0;
    logic [SAMPLE_W-1:0] r_ch1;
    logic [SAMPLE_W-1:0] r_prev_ch0;
    logic                r_have_prev;
    logic                r_fault;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_ch0;
    logic [SAMPLE_W-1:0] r_out_mean;
    logic                r_out_fault;
    logic                in_take;
    logic                out_free;
    logic                out_load;
    logic [SAMPLE_W-1:0] ref_ch0;
    logic [SAMPLE_W-1:0] jump;
    logic                n_fault;
    logic [SUM_W-1:0]    win_sum;
    logic [CNT_W-1:0]    win_fill;
    t_div_req            div_req;
    logic                div_busy;
    logic [SUM_W-1:0]    div_quo;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_take     = i_valid && o_ready;
    assign out_free    = !r_out_valid || i_ready;
    assign out_load    = (r_state == S_DONE) && out_free;

    // Limit registers; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_limit  <= LOW_LIMIT_RST;
            r_jump_limit <= JUMP_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LOW_LIMIT:  r_low_limit  <= i_cfg_data;
                REG_JUMP_LIMIT: r_jump_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_valid) n_state = S_UPDATE;
            S_UPDATE: n_state = S_LOAD;
            S_LOAD:   n_state = S_DIVIDE;
            S_DIVIDE: if (!div_busy) n_state = S_DONE;
            S_DONE:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the request's samples while it is worked on.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_ch0 <= i_ch0_sample;
            r_ch1 <= i_ch1_sample;
        end
    end

    // Alarm check; the first sample after reset is compared with itself.
    always_comb begin
        ref_ch0 = r_have_prev ? r_prev_ch0 : r_ch0;
        jump    = (ref_ch0 > r_ch0) ? ref_ch0 - r_ch0 : r_ch0 - ref_ch0;
        n_fault = (r_ch0 < r_low_limit) || (jump > r_jump_limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
        end else if (r_state == S_UPDATE) begin
            r_have_prev <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_UPDATE) begin
            r_prev_ch0 <= r_ch0;
            r_fault    <= n_fault;
        end
    end

    adcavg_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (r_state == S_UPDATE),
        .i_sample (r_ch1),
        .o_sum    (win_sum),
        .o_fill   (win_fill)
    );

    // The divider picks up the updated sum and count in the cycle after the update.
    always_comb begin
        div_req.start    = (r_state == S_LOAD);
        div_req.dividend = win_sum;
        div_req.divisor  = win_fill;
    end

    adcavg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_ch0   <= r_ch0;
            r_out_mean  <= div_quo[SAMPLE_W-1:0];
            r_out_fault <= r_fault;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_ch0_value = r_out_ch0;
    assign o_ch1_mean  = r_out_mean;
    assign o_fault     = r_out_fault;

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised without a finished divide");

    a_div_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVIDE) && !div_busy |=> (r_state == S_DONE))
        else $error("sequencer missed the end of the divide");

endmodule
